### hw/rtl/cookie_value_quote_encoder_defines.svh
// ----------------------------------------------------------------------------
// Cookie value quote encoder: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COOKIE_VALUE_QUOTE_ENCODER_DEFINES_SVH
`define COOKIE_VALUE_QUOTE_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CKQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cookie encoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CKQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cookie encoder: next-cycle check failed");

`endif

### hw/rtl/ckq_pkg.sv
// ----------------------------------------------------------------------------
// Cookie value quote encoder package
// Sizes, character codes, phase codes and the byte classification functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ckq_pkg;

    localparam int MAX_LEN = 256;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = $clog2(MAX_LEN);

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FETCH  = 1'b1;

    localparam logic [1:0] PH_OPEN  = 2'd0;
    localparam logic [1:0] PH_BODY  = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_LAST = 2'd3;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             quote;
        logic             complete;
        logic [LEN_W-1:0] rd_idx;
        logic [1:0]       phase;
        logic [1:0]       esc;
    } ckq_ctx_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       valid;
    } ckq_res_t;

    // Token bytes: printable ASCII other than the separator characters.
    function automatic logic is_token_byte(input logic [7:0] c);
        logic ok;
        if (c < 8'h21 || c > 8'h7E) begin
            ok = 1'b0;
        end else if (c inside {8'h22, 8'h28, 8'h29, 8'h2C, 8'h2F, 8'h3A, 8'h3B,
                               8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5C,
                               8'h5D, 8'h7B, 8'h7D}) begin
            ok = 1'b0;
        end else begin
            ok = 1'b1;
        end
        return ok;
    endfunction

    function automatic logic needs_octal(input logic [7:0] c);
        return (c < 8'h20) || (c == CH_COMMA) || (c == CH_SEMICOLON) || (c >= 8'h7F);
    endfunction

endpackage

### hw/rtl/ckq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ckq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/ckq_step.sv
// ----------------------------------------------------------------------------
// Cookie value encoder step
// Produces at most one encoded output byte from the fetch context and the
// stored byte at the read index, and gives the context after that byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ckq_step (
    input  ckq_pkg::ckq_ctx_t ctx,
    input  logic [7:0]        text,
    output ckq_pkg::ckq_ctx_t ctx_next,
    output ckq_pkg::ckq_res_t res
);
    import ckq_pkg::*;

    logic [LEN_W-1:0] idx_inc;

    assign idx_inc = ctx.rd_idx + LEN_W'(1);

    always_comb
    begin
        ckq_ctx_t nx;
        ckq_res_t r;
        logic     advance;
        logic [2:0] digit;

        nx      = ctx;
        r       = '0;
        advance = 1'b0;
        digit   = 3'd0;

        if (ctx.complete)
        begin
            if (nx.phase == PH_OPEN)
            begin
                if (ctx.length == '0)
                begin
                    nx.phase = PH_DONE;
                end
                else if (ctx.quote)
                begin
                    r.data   = CH_QUOTE;
                    r.valid  = 1'b1;
                    nx.phase = PH_BODY;
                end
                else
                begin
                    nx.phase = PH_BODY;
                end
            end

            if (!r.valid && nx.phase == PH_BODY && ctx.rd_idx < ctx.length)
            begin
                r.valid = 1'b1;
                if (!ctx.quote)
                begin
                    r.data  = text;
                    advance = 1'b1;
                end
                else if (text == CH_QUOTE || text == CH_BACKSLASH)
                begin
                    if (ctx.esc == ESC_NONE)
                    begin
                        r.data = CH_BACKSLASH;
                        nx.esc = 2'd1;
                    end
                    else
                    begin
                        r.data  = text;
                        advance = 1'b1;
                    end
                end
                else if (needs_octal(text))
                begin
                    case (ctx.esc)
                        2'd1:    digit = text[7:6] == 2'b00 ? 3'd0 : {1'b0, text[7:6]};
                        2'd2:    digit = text[5:3];
                        default: digit = text[2:0];
                    endcase
                    if (ctx.esc == ESC_NONE)
                    begin
                        r.data = CH_BACKSLASH;
                    end
                    else
                    begin
                        r.data = CH_ZERO | {5'd0, digit};
                    end
                    if (ctx.esc == ESC_LAST)
                    begin
                        advance = 1'b1;
                    end
                    else
                    begin
                        nx.esc = ctx.esc + 2'd1;
                    end
                end
                else
                begin
                    r.data  = text;
                    advance = 1'b1;
                end

                if (advance)
                begin
                    nx.esc    = ESC_NONE;
                    nx.rd_idx = idx_inc;
                    if (idx_inc >= ctx.length)
                    begin
                        nx.phase = ctx.quote ? PH_CLOSE : PH_DONE;
                        // An unquoted value ends on its own last byte.
                        r.last   = !ctx.quote;
                    end
                end
            end
            else if (!r.valid && nx.phase == PH_CLOSE)
            begin
                r.data   = CH_QUOTE;
                r.valid  = 1'b1;
                r.last   = 1'b1;
                nx.phase = PH_DONE;
            end
        end

        ctx_next = nx;
        res      = r;
    end

endmodule

### hw/rtl/cookie_value_quote_encoder.sv
// ----------------------------------------------------------------------------
// Cookie value quote encoder
// Stores a cookie value in a byte RAM and returns its encoding, quoted
// when needed, one byte per fetch transaction.
// ----------------------------------------------------------------------------
// Append transactions: the byte is written to the RAM at the accept edge
// unless the value is full, and busy stays low.
// Fetch transactions: the RAM read is registered, then the result is
// registered; strobe is high in the first cycle in which busy is low again.
// Reset clears all control state; the value RAM is not cleared and needs none.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cookie_value_quote_encoder_defines.svh"

module cookie_value_quote_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       opcode,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       strobe,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_valid,
    output logic       overflow
);
    import ckq_pkg::*;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_FETCH = 1'b1;

    logic              state_reg, state_next;
    ckq_ctx_t          ctx_reg, ctx_next;
    logic              ovf_reg, ovf_next;
    logic              strobe_reg, strobe_next;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_valid_reg;
    logic              overflow_reg;

    logic              accept;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_rdata;
    ckq_ctx_t          app_base;
    ckq_ctx_t          step_ctx;
    ckq_res_t          step_res;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_FETCH);

    // A finished value is discarded by the first append that follows it.
    always_comb
    begin
        app_base = ctx_reg;
        if (ctx_reg.complete)
        begin
            app_base = '0;
            app_base.phase = PH_OPEN;
            app_base.esc   = ESC_NONE;
        end
    end

    assign ram_waddr = app_base.length[ADDR_W-1:0];

    ckq_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_text_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (data_byte),
        .raddr (ctx_reg.rd_idx[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    ckq_step u_step (
        .ctx      (ctx_reg),
        .text     (ram_rdata),
        .ctx_next (step_ctx),
        .res      (step_res)
    );

    always_comb
    begin
        state_next  = state_reg;
        ctx_next    = ctx_reg;
        ovf_next    = ovf_reg;
        strobe_next = 1'b0;
        ram_we      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && opcode == OP_APPEND)
                begin
                    ctx_next = app_base;
                    ovf_next = ctx_reg.complete ? 1'b0 : ovf_reg;
                    if (app_base.length < LEN_W'(MAX_LEN))
                    begin
                        ram_we          = 1'b1;
                        ctx_next.length = app_base.length + LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (!is_token_byte(data_byte))
                    begin
                        ctx_next.quote = 1'b1;
                    end
                    if (last_byte)
                    begin
                        ctx_next.complete = 1'b1;
                    end
                end
                else if (accept)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                ctx_next    = step_ctx;
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // An all-zero context is the opening-quote phase with no escape pending.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ctx_reg          <= '0;
            ovf_reg          <= 1'b0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ctx_reg    <= ctx_next;
            ovf_reg    <= ovf_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FETCH)
        begin
            out_byte_reg  <= step_res.data;
            out_last_reg  <= step_res.last;
            out_valid_reg <= step_res.valid;
            overflow_reg  <= ovf_reg;
        end
    end

    assign strobe    = strobe_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;
    assign overflow  = overflow_reg;

    `CKQ_ASSERT_NEXT(a_strobe_after_fetch, state_reg == S_FETCH, strobe_reg)
    `CKQ_ASSERT_SAME(a_len_bound, 1'b1, ctx_reg.length <= LEN_W'(MAX_LEN))
    `CKQ_ASSERT_SAME(a_idx_bound, 1'b1, ctx_reg.rd_idx <= ctx_reg.length)
    `CKQ_ASSERT_SAME(a_esc_in_body, ctx_reg.esc != ESC_NONE,
                     ctx_reg.phase == PH_BODY && ctx_reg.quote)
    `CKQ_ASSERT_SAME(a_last_is_valid, strobe_reg && out_last_reg, out_valid_reg)

endmodule
